[rtl/phi4ms_pkg.sv]
// phi4ms_pkg: widths, register indexes, item types and exp tables for the
// phi^4 lattice metropolis site update block
// no dependencies
package phi4ms_pkg;

    localparam int FRAC_BITS   = 12;
    localparam int FIELD_W     = 18;
    localparam int SMP_W       = 16;
    localparam int REG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam int SUM_W       = FIELD_W + 2;
    localparam int AMUL_W      = SUM_W + REG_W + 1;
    localparam int ALPHA_W     = SUM_W;
    localparam int NPROD_W     = SMP_W + REG_W + 1;
    localparam int PROP_W      = NPROD_W + 1;
    localparam int SQ_W        = 2 * FIELD_W - 1 - FRAC_BITS;
    localparam int QD_W        = 2 * SQ_W - 1 - FRAC_BITS;

    localparam int EXP_INT_LEN = 12;
    localparam int EXP_IDX_W   = 4;
    localparam int EXPI_W      = 17;
    localparam int EXPF_W      = 16;
    localparam int PROD_W      = EXPI_W + EXPF_W;
    localparam int PROB_W      = PROD_W - 16;
    localparam int ROUND_HALF  = 32768;

    localparam int FIELD_MAX_I = 2 ** (FIELD_W - 1) - 1;
    localparam int FIELD_MIN_I = -(2 ** (FIELD_W - 1));

    localparam logic [REG_W-1:0] HOPPING_GAIN_RST     = 16'd19661;
    localparam logic [REG_W-1:0] QUARTIC_COUPLING_RST = 16'd655;
    localparam logic [REG_W-1:0] PROPOSAL_WIDTH_RST   = 16'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOPPING_GAIN     = 2'd0,
        CFG_QUARTIC_COUPLING = 2'd1,
        CFG_PROPOSAL_WIDTH   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] hopping_gain;
        logic [REG_W-1:0] quartic_coupling;
        logic [REG_W-1:0] proposal_width;
    } cfg_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] prop;
        logic signed [FIELD_W-1:0] old;
        logic [SMP_W-1:0]          uni;
    } prop_item_t;

    // round(65536*exp(-i))
    function automatic logic [EXPI_W-1:0] exp_int(input logic [EXP_IDX_W-1:0] idx);
        logic [EXPI_W-1:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round(65536*exp(-k/16)), top entry saturates to 16 bits plus carry
    function automatic logic [EXPI_W-1:0] exp_frac(input logic [EXP_IDX_W-1:0] idx);
        logic [EXPI_W-1:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            4'd15:   v = 17'd25664;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/phi4ms_if.sv]
// phi4ms_if: valid/ready channel interfaces for site items and results
// depends on phi4ms_pkg
interface phi4ms_sample_if;
    import phi4ms_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] old_value;
    logic signed [FIELD_W-1:0] left_value;
    logic signed [FIELD_W-1:0] right_value;
    logic signed [FIELD_W-1:0] up_value;
    logic signed [FIELD_W-1:0] down_value;
    logic signed [SMP_W-1:0]   normal_sample;
    logic [SMP_W-1:0]          uniform_sample;

    modport source (
        output valid, old_value, left_value, right_value, up_value, down_value,
               normal_sample, uniform_sample,
        input  ready
    );
    modport sink (
        input  valid, old_value, left_value, right_value, up_value, down_value,
               normal_sample, uniform_sample,
        output ready
    );
endinterface

interface phi4ms_result_if;
    import phi4ms_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] new_value;
    logic                      accepted;

    modport source (
        output valid, new_value, accepted,
        input  ready
    );
    modport sink (
        input  valid, new_value, accepted,
        output ready
    );
endinterface

[rtl/phi4ms_cfg.sv]
// phi4ms_cfg: coupling and proposal registers behind the write port
// depends on phi4ms_pkg
module phi4ms_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [phi4ms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [phi4ms_pkg::REG_W-1:0]   cfg_data,
    output phi4ms_pkg::cfg_t               cfg
);
    import phi4ms_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HOPPING_GAIN:     cfg_next.hopping_gain     = cfg_data;
                CFG_QUARTIC_COUPLING: cfg_next.quartic_coupling = cfg_data;
                CFG_PROPOSAL_WIDTH:   cfg_next.proposal_width   = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hopping_gain     <= HOPPING_GAIN_RST;
            cfg_reg.quartic_coupling <= QUARTIC_COUPLING_RST;
            cfg_reg.proposal_width   <= PROPOSAL_WIDTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/phi4ms_prop.sv]
// phi4ms_prop: three-stage proposal pipeline, neighbour sum times kappa
// plus sigma times normal sample, saturated to the field range
// depends on phi4ms_pkg and phi4ms_sample_if
module phi4ms_prop (
    input  logic                     clk,
    input  logic                     rst_n,
    input  phi4ms_pkg::cfg_t         cfg,
    phi4ms_sample_if.sink            sample,
    output logic                     item_valid,
    input  logic                     item_ready,
    output phi4ms_pkg::prop_item_t   item
);
    import phi4ms_pkg::*;

    localparam int NSTG = 3;

    localparam logic signed [PROP_W-1:0] PROP_MAX = PROP_W'(FIELD_MAX_I);
    localparam logic signed [PROP_W-1:0] PROP_MIN = PROP_W'(FIELD_MIN_I);

    typedef struct packed {
        logic signed [FIELD_W-1:0] old;
        logic [SMP_W-1:0]          uni;
    } carry_t;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG:0]   rdy;

    // stage 0
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [NPROD_W-1:0] nprod_reg;
    logic signed [NPROD_W-1:0] nprod_next;
    carry_t                    c0_reg;
    carry_t                    c0_next;
    // stage 1
    logic signed [AMUL_W-1:0]  amul;
    logic signed [AMUL_W-1:0]  amul_sh;
    logic signed [ALPHA_W-1:0] alpha_reg;
    logic signed [ALPHA_W-1:0] alpha_next;
    logic signed [NPROD_W-1:0] noise_reg;
    logic signed [NPROD_W-1:0] noise_next;
    carry_t                    c1_reg;
    // stage 2
    logic signed [PROP_W-1:0]  prop_full;
    logic                      ovf_hi;
    logic                      ovf_lo;
    logic signed [FIELD_W-1:0] prop_reg;
    logic signed [FIELD_W-1:0] prop_next;
    carry_t                    c2_reg;

    always_comb
    begin
        rdy[NSTG] = item_ready;
        for (int s = NSTG - 1; s >= 0; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = sample.valid;
        end
        for (int s = 1; s < NSTG; s++)
        begin
            if (rdy[s])
            begin
                vld_next[s] = vld_reg[s-1];
            end
        end
    end

    always_comb
    begin
        sum_next = SUM_W'(sample.left_value) + SUM_W'(sample.right_value)
                 + SUM_W'(sample.up_value) + SUM_W'(sample.down_value);
        nprod_next  = NPROD_W'(sample.normal_sample)
                    * NPROD_W'($signed({1'b0, cfg.proposal_width}));
        c0_next.old = sample.old_value;
        c0_next.uni = sample.uniform_sample;

        amul       = AMUL_W'(sum_reg) * AMUL_W'($signed({1'b0, cfg.hopping_gain}));
        amul_sh    = amul >>> REG_W;
        alpha_next = amul_sh[ALPHA_W-1:0];
        noise_next = nprod_reg >>> FRAC_BITS;

        prop_full = PROP_W'(alpha_reg) + PROP_W'(noise_reg);
        ovf_hi    = prop_full > PROP_MAX;
        ovf_lo    = prop_full < PROP_MIN;
        if (ovf_hi)
            prop_next = PROP_MAX[FIELD_W-1:0];
        else if (ovf_lo)
            prop_next = PROP_MIN[FIELD_W-1:0];
        else
            prop_next = prop_full[FIELD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            sum_reg   <= sum_next;
            nprod_reg <= nprod_next;
            c0_reg    <= c0_next;
        end
        if (rdy[1])
        begin
            alpha_reg <= alpha_next;
            noise_reg <= noise_next;
            c1_reg    <= c0_reg;
        end
        if (rdy[2])
        begin
            prop_reg <= prop_next;
            c2_reg   <= c1_reg;
        end
    end

    assign sample.ready = rdy[0];
    assign item_valid   = vld_reg[NSTG-1];
    assign item.prop    = prop_reg;
    assign item.old     = c2_reg.old;
    assign item.uni     = c2_reg.uni;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rdy[0] |-> (&vld_reg))
        else $error("proposal pipeline stalls input with an empty stage");

    a_sat_high: assert property (@(posedge clk) disable iff (!rst_n)
        rdy[2] && vld_reg[1] && ovf_hi |=> prop_reg == PROP_MAX[FIELD_W-1:0])
        else $error("proposal above field range not clamped");

endmodule

[rtl/phi4ms_accept.sv]
// phi4ms_accept: seven-stage acceptance pipeline, fourth powers, scaled
// energy step, table exp and uniform compare, ending in the result register
// depends on phi4ms_pkg and phi4ms_result_if
module phi4ms_accept (
    input  logic                     clk,
    input  logic                     rst_n,
    input  phi4ms_pkg::cfg_t         cfg,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  phi4ms_pkg::prop_item_t   item,
    phi4ms_result_if.source          result
);
    import phi4ms_pkg::*;

    localparam int NSTG  = 7;
    localparam int NCARY = NSTG - 1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] prop;
        logic signed [FIELD_W-1:0] old;
        logic [SMP_W-1:0]          uni;
        logic                      early;
    } carry_t;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG:0]   rdy;

    carry_t carry_reg [NCARY];
    carry_t carry_next;

    logic [FIELD_W-1:0]     mag_old_next;
    logic [FIELD_W-1:0]     mag_new_next;
    logic [FIELD_W-1:0]     mag_old_reg;
    logic [FIELD_W-1:0]     mag_new_reg;
    logic [2*FIELD_W-1:0]   msq_old;
    logic [2*FIELD_W-1:0]   msq_new;
    logic [SQ_W-1:0]        sq_old_reg;
    logic [SQ_W-1:0]        sq_new_reg;
    logic [2*SQ_W-1:0]      mq_old;
    logic [2*SQ_W-1:0]      mq_new;
    logic [QD_W-1:0]        q_old_reg;
    logic [QD_W-1:0]        q_new_reg;
    logic [QD_W-1:0]        diff_next;
    logic [QD_W-1:0]        diff_reg;
    logic [QD_W+REG_W-1:0]  gmul;
    logic [QD_W-1:0]        a_next;
    logic [QD_W-1:0]        a_reg;
    logic [QD_W-1:0]        a_int;
    logic                   big_next;
    logic                   big_reg;
    logic [EXP_IDX_W-1:0]   i_idx;
    logic [EXP_IDX_W-1:0]   k_idx;
    logic [EXPI_W-1:0]      ti;
    logic [EXPI_W-1:0]      tf;
    logic [PROD_W-1:0]      prod_next;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      psum;
    logic [PROB_W-1:0]      prob;
    logic                   take;
    logic signed [FIELD_W-1:0] new_value_next;
    logic signed [FIELD_W-1:0] new_value_reg;
    logic                   accepted_reg;

    always_comb
    begin
        rdy[NSTG] = result.ready;
        for (int s = NSTG - 1; s >= 0; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = item_valid;
        end
        for (int s = 1; s < NSTG; s++)
        begin
            if (rdy[s])
            begin
                vld_next[s] = vld_reg[s-1];
            end
        end
    end

    always_comb
    begin
        mag_old_next = item.old[FIELD_W-1] ? (~item.old + FIELD_W'(1)) : item.old;
        mag_new_next = item.prop[FIELD_W-1] ? (~item.prop + FIELD_W'(1)) : item.prop;
        carry_next.prop  = item.prop;
        carry_next.old   = item.old;
        carry_next.uni   = item.uni;
        carry_next.early = mag_old_next >= mag_new_next;

        msq_old = {{FIELD_W{1'b0}}, mag_old_reg} * {{FIELD_W{1'b0}}, mag_old_reg};
        msq_new = {{FIELD_W{1'b0}}, mag_new_reg} * {{FIELD_W{1'b0}}, mag_new_reg};

        mq_old = {{SQ_W{1'b0}}, sq_old_reg} * {{SQ_W{1'b0}}, sq_old_reg};
        mq_new = {{SQ_W{1'b0}}, sq_new_reg} * {{SQ_W{1'b0}}, sq_new_reg};

        diff_next = q_new_reg - q_old_reg;

        gmul   = {{REG_W{1'b0}}, diff_reg} * {{QD_W{1'b0}}, cfg.quartic_coupling};
        a_next = gmul[REG_W +: QD_W];

        // integer and sixteenth parts of the exponent
        a_int     = a_reg >> FRAC_BITS;
        big_next  = a_int >= QD_W'(EXP_INT_LEN);
        i_idx     = a_reg[FRAC_BITS +: EXP_IDX_W];
        k_idx     = a_reg[FRAC_BITS-EXP_IDX_W +: EXP_IDX_W];
        ti        = exp_int(i_idx);
        tf        = exp_frac(k_idx);
        prod_next = PROD_W'(ti) * PROD_W'(tf[EXPF_W-1:0])
                  + (tf[EXPF_W] ? PROD_W'(ti) << EXPF_W : '0);

        psum = prod_reg + PROD_W'(ROUND_HALF);
        prob = psum[PROD_W-1 -: PROB_W];
        take = carry_reg[NCARY-1].early
            || (!big_reg && ({1'b0, carry_reg[NCARY-1].uni} < prob));
        new_value_next = take ? carry_reg[NCARY-1].prop : carry_reg[NCARY-1].old;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            carry_reg[0] <= carry_next;
            mag_old_reg  <= mag_old_next;
            mag_new_reg  <= mag_new_next;
        end
        for (int s = 1; s < NCARY; s++)
        begin
            if (rdy[s])
            begin
                carry_reg[s] <= carry_reg[s-1];
            end
        end
        if (rdy[1])
        begin
            sq_old_reg <= msq_old[FRAC_BITS +: SQ_W];
            sq_new_reg <= msq_new[FRAC_BITS +: SQ_W];
        end
        if (rdy[2])
        begin
            q_old_reg <= mq_old[FRAC_BITS +: QD_W];
            q_new_reg <= mq_new[FRAC_BITS +: QD_W];
        end
        if (rdy[3])
        begin
            diff_reg <= diff_next;
        end
        if (rdy[4])
        begin
            a_reg <= a_next;
        end
        if (rdy[5])
        begin
            prod_reg <= prod_next;
            big_reg  <= big_next;
        end
        if (rdy[6])
        begin
            new_value_reg <= new_value_next;
            accepted_reg  <= take;
        end
    end

    assign item_ready       = rdy[0];
    assign result.valid     = vld_reg[NSTG-1];
    assign result.new_value = new_value_reg;
    assign result.accepted  = accepted_reg;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rdy[0] |-> (&vld_reg))
        else $error("acceptance pipeline stalls input with an empty stage");

    a_quartic_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && !carry_reg[2].early |-> q_new_reg >= q_old_reg)
        else $error("larger proposal magnitude gave smaller fourth power");

    a_big_reject: assert property (@(posedge clk) disable iff (!rst_n)
        rdy[6] && vld_reg[5] && big_reg && !carry_reg[NCARY-1].early
        |=> !accepted_reg)
        else $error("proposal accepted with exponent beyond table");

endmodule

[rtl/phi4_lattice_metropolis_site_update_top.sv]
// path: an accepted item passes the proposal stages, then the acceptance stages, to the result register
// throughput: one item per cycle while results are taken; every stage holds its item under stall
// an empty stage still takes a new item while a result waits to be taken
// reset: pipeline valid bits cleared, registers back to kappa 19661,
// g 655 and sigma 4096; depends on phi4ms_pkg, phi4ms_if, phi4ms_cfg,
// phi4ms_prop and phi4ms_accept
module phi4_lattice_metropolis_site_update_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [phi4ms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [phi4ms_pkg::REG_W-1:0]     cfg_data,
    phi4ms_sample_if.sink                    sample,
    phi4ms_result_if.source                  result
);
    import phi4ms_pkg::*;

    cfg_t       cfg;
    logic       item_valid;
    logic       item_ready;
    prop_item_t item;

    phi4ms_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    phi4ms_prop u_prop (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample     (sample),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    phi4ms_accept u_accept (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .result     (result)
    );

endmodule
